>>> design/cfq_pkg.sv
package cfq_pkg;

    localparam int unsigned DATA_W = 32;

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_DELETE  = 2'd1,
        CMD_DISPLAY = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_DISP
    } state_t;

    // Per-cell control: load takes priority over shift.
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

    typedef logic signed [DATA_W-1:0] word_t;

endpackage

>>> design/cfq_cell.sv
module cfq_cell (
    input  logic               aclk,
    input  cfq_pkg::cell_ctrl_t ctrl,
    input  cfq_pkg::word_t      load_data,
    input  cfq_pkg::word_t      shift_data,
    output cfq_pkg::word_t      data_q
);
    import cfq_pkg::*;

    word_t data_reg;
    word_t data_next;

    // Load a fresh word, or take the neighbor's word, or hold.
    always_comb begin
        data_next = data_reg;
        if (ctrl.load) begin
            data_next = load_data;
        end else if (ctrl.shift) begin
            data_next = shift_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_q = data_reg;

endmodule

>>> design/circular_fifo_queue_core.sv
// Channel   | Direction | Payload
// ----------+-----------+-----------------------------------------------------
// s_ (cmd)  | in        | s_tuser: command[1:0]; s_tdata: value[31:0]
// m_ (res)  | out       | m_tuser: status[1:0]; m_tdata: data[31:0]; m_tlast
//
// Insert, delete and any empty/full report each return a single result.
// Display of N entries enters the display state, then emits one result per
// cycle while output is free, the row rotating one position, oldest word first.
// Reset clears the entry count, display sequencer and output valid flag;
// cell contents are left as they are and are never read before written.
// A stall on m_tready holds the output register and pauses a display; a new
// command is taken only while no display runs and the output stage is free.
module circular_fifo_queue_core #(
    parameter int unsigned DEPTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // command transfer
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [1:0]  s_tuser,   // [1:0] command
    // result transfer
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] data
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast
);
    import cfq_pkg::*;

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned IDX_W = $clog2(DEPTH);

    // Control state
    state_t            state_reg,   state_next;
    logic [CNT_W-1:0]  count_reg,   count_next;
    logic [IDX_W-1:0]  idx_reg,     idx_next;

    // Output stage
    logic              m_valid_reg,  m_valid_next;
    status_t           m_status_reg, m_status_next;
    word_t             m_data_reg,   m_data_next;
    logic              m_last_reg,   m_last_next;

    // Cell row control
    logic              load_en;
    logic [IDX_W-1:0]  load_sel;
    word_t             load_data;
    logic              shift_en;
    word_t             cell_q [DEPTH];

    logic              out_free;
    logic              in_fire;
    cmd_t              cmd;
    logic              disp_last;
    logic [CNT_W-1:0]  count_dec;

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign in_fire   = s_tvalid && s_tready;
    assign cmd       = cmd_t'(s_tuser);
    assign count_dec = count_reg - CNT_W'(1);
    assign disp_last = (CNT_W'(idx_reg) == count_dec);

    // Row of cells: outside a display, cell 0 holds the oldest word. A shift moves every
    // word one cell toward cell 0; during display the word leaving cell 0 is
    // reloaded at the tail so the row is back in order after a full pass.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        cell_ctrl_t ctrl;
        word_t      neighbor;

        assign ctrl.load  = load_en && (load_sel == IDX_W'(i));
        assign ctrl.shift = shift_en;

        if (i == DEPTH - 1) begin : g_tail
            assign neighbor = '0;
        end else begin : g_body
            assign neighbor = cell_q[i+1];
        end

        cfq_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .load_data  (load_data),
            .shift_data (neighbor),
            .data_q     (cell_q[i])
        );
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;
        load_en       = 1'b0;
        load_sel      = count_reg[IDX_W-1:0];
        load_data     = word_t'(s_tdata);
        shift_en      = 1'b0;

        // Drop the held result once it is taken.
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    case (cmd)
                        CMD_INSERT: begin
                            m_valid_next = 1'b1;
                            m_data_next  = '0;
                            m_last_next  = 1'b1;
                            if (count_reg == CNT_W'(DEPTH)) begin
                                m_status_next = STAT_FULL;
                            end else begin
                                // Append at the first free cell.
                                m_status_next = STAT_OK;
                                load_en       = 1'b1;
                                count_next    = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_DELETE: begin
                            m_valid_next = 1'b1;
                            m_last_next  = 1'b1;
                            if (count_reg == '0) begin
                                m_status_next = STAT_EMPTY;
                                m_data_next   = '0;
                            end else begin
                                // Pop cell 0 and advance the row.
                                m_status_next = STAT_OK;
                                m_data_next   = cell_q[0];
                                shift_en      = 1'b1;
                                count_next    = count_dec;
                            end
                        end
                        CMD_DISPLAY: begin
                            if (count_reg == '0) begin
                                m_valid_next  = 1'b1;
                                m_status_next = STAT_EMPTY;
                                m_data_next   = '0;
                                m_last_next   = 1'b1;
                            end else begin
                                state_next = ST_DISP;
                                idx_next   = '0;
                            end
                        end
                        default: begin
                            // Unused command: no result, no state change.
                        end
                    endcase
                end
            end
            ST_DISP: begin
                if (out_free) begin
                    // Emit the word at cell 0 and rotate it to the tail.
                    m_valid_next  = 1'b1;
                    m_status_next = STAT_OK;
                    m_data_next   = cell_q[0];
                    m_last_next   = disp_last;
                    shift_en      = 1'b1;
                    load_en       = 1'b1;
                    load_sel      = count_dec[IDX_W-1:0];
                    load_data     = cell_q[0];
                    if (disp_last) begin
                        state_next = ST_IDLE;
                        idx_next   = '0;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // Entry count never exceeds the row length.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // A display only runs over a non-empty row, and its index stays inside it.
    a_disp_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DISP) |-> (count_reg != '0 && CNT_W'(idx_reg) < count_reg))
        else $error("display index outside stored entries");

    // Entry count holds while a display walks the row.
    a_disp_count_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DISP) |=> (state_reg != ST_DISP || $stable(count_reg)))
        else $error("entry count changed during display");

    // A result without last only comes from a display still in progress.
    a_nonlast_in_disp: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_last_reg) |-> (state_reg == ST_DISP))
        else $error("non-final result outside display");

endmodule
